### rtl/bracket_pair_finder_defines.svh
// Assertion macros shared by the bracket pair finder RTL.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef BRACKET_PAIR_FINDER_DEFINES_SVH
`define BRACKET_PAIR_FINDER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define BPF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("bracket pair finder assertion failed");

// When the trigger holds, the outcome must hold in the cycle after.
`define BPF_ASSERT_NEXT(label, trig, outcome) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (outcome)) \
        else $error("bracket pair finder assertion failed");

`endif

### rtl/bpf_pkg.sv
// Package for the bracket pair finder: field widths, control state and cell command.
// Depends on nothing; used by the interfaces, the cell and the top level.
`default_nettype none

package bpf_pkg;

    localparam int KEY_W     = 21;
    localparam int OUT_POS_W = 16;

    typedef enum logic {
        ST_IDLE,
        ST_PICK
    } t_state;

    typedef struct packed {
        logic             push;
        logic             search;
        logic [KEY_W-1:0] key;
    } t_cell_cmd;

endpackage

`default_nettype wire

### rtl/bpf_req_if.sv
// Request channel of the bracket pair finder: one classified character per request.
// Depends on bpf_pkg for the key width.
`default_nettype none

interface bpf_req_if;
    logic                      valid;
    logic                      ready;
    logic                      is_bracket;
    logic                      is_opening;
    logic [bpf_pkg::KEY_W-1:0] bracket_key;
    logic                      end_of_text;

    modport source (output valid, is_bracket, is_opening, bracket_key, end_of_text,
                    input ready);
    modport sink   (input valid, is_bracket, is_opening, bracket_key, end_of_text,
                    output ready);
endinterface

`default_nettype wire

### rtl/bpf_res_if.sv
// Result channel of the bracket pair finder: one matched pair of positions per request.
// Depends on bpf_pkg for the position width.
`default_nettype none

interface bpf_res_if;
    logic                          valid;
    logic                          ready;
    logic [bpf_pkg::OUT_POS_W-1:0] open_position;
    logic [bpf_pkg::OUT_POS_W-1:0] close_position;

    modport source (output valid, open_position, close_position, input ready);
    modport sink   (input valid, open_position, close_position, output ready);
endinterface

`default_nettype wire

### rtl/bpf_cell.sv
// One stack entry of the bracket pair finder with its key compare and match chain link.
// Depends on bpf_pkg for the cell command type.
`default_nettype none

module bpf_cell #(
    parameter int STACK_DEPTH   = 63,
    parameter int POSITION_BITS = 16,
    parameter int CELL_IDX      = 0,
    parameter int CW            = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire bpf_pkg::t_cell_cmd       i_cmd,
    input  wire logic [CW-1:0]            i_count,
    input  wire logic [POSITION_BITS-1:0] i_pos,
    input  wire logic                     i_above_hit,
    input  wire logic [POSITION_BITS-1:0] i_above_pos,
    input  wire logic [CW-1:0]            i_above_idx,
    output logic                          o_hit,
    output logic [POSITION_BITS-1:0]      o_pos,
    output logic [CW-1:0]                 o_idx
);
    import bpf_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(CELL_IDX);

    logic [KEY_W-1:0]         r_key;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_hit;
    logic                     w_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (i_count == IDX)) begin
            r_key <= i_cmd.key;
            r_pos <= i_pos;
        end
        if (i_cmd.search) begin
            r_hit <= (IDX < i_count) && (r_key == i_cmd.key);
        end
    end

    // The topmost hit wins; cells below it only pass along what came from above.
    assign w_sel = r_hit && !i_above_hit;
    assign o_hit = i_above_hit || r_hit;
    assign o_pos = i_above_pos | (w_sel ? r_pos : '0);
    assign o_idx = i_above_idx | (w_sel ? IDX : '0);

endmodule

`default_nettype wire

### rtl/bracket_pair_finder.sv
// A non-bracket or opening bracket needs no pick; a closing bracket moves control to
// the pick state, which loads a matched pair into the output register once it is free.
// Throughput: one request per cycle outside the pick state, which stalls on full output;
// set by the registered key compare in every cell followed by the topmost-hit chain.
// Reset is synchronous and active low; it clears the state, stack count, position, halt
// flag and output valid, while the stack entries themselves are not cleared.
`default_nettype none
`include "bracket_pair_finder_defines.svh"

module bracket_pair_finder #(
    parameter int STACK_DEPTH   = 63,
    parameter int POSITION_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bpf_req_if.sink   i_req,
    bpf_res_if.source o_res
);
    import bpf_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [POSITION_BITS-1:0] r_char_pos, n_char_pos;
    logic                     r_halted, n_halted;
    logic                     r_eot;
    logic [OUT_POS_W-1:0]     r_close_pos;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_POS_W-1:0]     r_open_out, r_close_out;

    t_cell_cmd                w_cmd;
    logic                     w_accept;
    logic                     w_active;
    logic                     w_close;
    logic                     w_load;
    logic                     w_pick_done;
    logic                     w_hit   [STACK_DEPTH+1];
    logic [POSITION_BITS-1:0] w_pos   [STACK_DEPTH+1];
    logic [CW-1:0]            w_idx   [STACK_DEPTH+1];

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_active    = i_req.is_bracket && !r_halted;
    assign w_close     = w_active && !i_req.is_opening;
    assign w_load      = (r_state == ST_PICK) && w_hit[0] && (!r_out_valid || o_res.ready);
    assign w_pick_done = (r_state == ST_PICK) && (!w_hit[0] || w_load);

    assign w_cmd.push   = w_accept && w_active && i_req.is_opening && (r_count < DEPTH_C);
    assign w_cmd.search = w_accept && w_close;
    assign w_cmd.key    = i_req.bracket_key;

    assign w_hit[STACK_DEPTH] = 1'b0;
    assign w_pos[STACK_DEPTH] = '0;
    assign w_idx[STACK_DEPTH] = '0;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        bpf_cell #(
            .STACK_DEPTH  (STACK_DEPTH),
            .POSITION_BITS(POSITION_BITS),
            .CELL_IDX     (g),
            .CW           (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_count    (r_count),
            .i_pos      (r_char_pos),
            .i_above_hit(w_hit[g+1]),
            .i_above_pos(w_pos[g+1]),
            .i_above_idx(w_idx[g+1]),
            .o_hit      (w_hit[g]),
            .o_pos      (w_pos[g]),
            .o_idx      (w_idx[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_close) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (w_pick_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready          = (r_state == ST_IDLE);
        o_res.valid          = r_out_valid;
        o_res.open_position  = r_open_out;
        o_res.close_position = r_close_out;
    end

    always_comb begin
        n_count     = r_count;
        n_char_pos  = r_char_pos;
        n_halted    = r_halted;
        n_out_valid = r_out_valid;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
        if (w_pick_done) begin
            if (r_eot) begin
                n_count = '0;
            end else if (w_hit[0]) begin
                n_count = w_idx[0];
            end
        end
        if (w_accept) begin
            if (w_cmd.push) begin
                n_count = r_count + 1'b1;
            end else if (w_active && i_req.is_opening) begin
                n_halted = 1'b1;
            end
            if (i_req.end_of_text) begin
                n_char_pos = '0;
                n_halted   = 1'b0;
                if (!w_close) begin
                    n_count = '0;
                end
            end else if (r_char_pos != '1) begin
                n_char_pos = r_char_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_char_pos  <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_char_pos  <= n_char_pos;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_eot       <= i_req.end_of_text;
            r_close_pos <= OUT_POS_W'(r_char_pos);
        end
        if (w_load) begin
            r_open_out  <= OUT_POS_W'(w_pos[0]);
            r_close_out <= r_close_pos;
        end
    end

    `BPF_ASSERT_ALWAYS(a_count_bound, r_count <= DEPTH_C)
    `BPF_ASSERT_ALWAYS(a_halt_full, !r_halted || (r_count == DEPTH_C))
    `BPF_ASSERT_ALWAYS(a_no_req_in_pick, (r_state != ST_PICK) || !i_req.ready)
    `BPF_ASSERT_NEXT(a_hit_cuts_stack, w_load, r_count < $past(r_count))

endmodule

`default_nettype wire
